FILE: src/cs2s_pkg.sv
`timescale 1ns / 1ps
package cs2s_pkg;

  localparam int COORD_BITS       = 16;
  localparam int ANGLE_ITERATIONS = 16;
  localparam int GUARD_BITS       = 16;
  localparam int TABLE_LEN        = 32;
  localparam int IDX_W            = $clog2(TABLE_LEN);
  // guard bits plus headroom for quadrant swap and two CORDIC gains
  localparam int VEC_W            = COORD_BITS + GUARD_BITS + 4;
  localparam int ANG_W            = 34;
  localparam int CONST_W          = 31;
  localparam int GPROD_W          = COORD_BITS + 1 + CONST_W;
  localparam int GAIN_SHIFT       = 14;
  localparam int Q13_SHIFT        = 47;
  localparam int MAG_W            = 32;
  localparam int QPROD_W          = MAG_W + CONST_W;
  localparam int POLAR_W          = 15;
  localparam int AZ_W             = 16;

  localparam logic signed [ANG_W-1:0] BAM_HALF_PI = 34'sd1073741824;
  localparam logic signed [ANG_W-1:0] BAM_PI      = 34'sd2147483648;
  localparam logic [CONST_W-1:0]      PI_Q29      = 31'd1686629713;
  localparam logic [CONST_W-1:0]      GAIN_Q30    = 31'd1768195363;
  localparam logic signed [AZ_W-1:0]  Q13_PI      = 16'sd25736;
  localparam logic signed [AZ_W-1:0]  Q13_HALF_PI = 16'sd12868;
  localparam logic signed [AZ_W-1:0]  AZ_LOW      = -16'sd25735;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ANG_W-1:0] a;
  } cs2s_vec_t;

  typedef struct packed {
    logic                    valid;
    logic                    x_zero;
    logic                    y_zero;
    logic                    x_pos;
    logic                    y_pos;
    logic                    z_zero;
    logic                    z_neg;
    logic [GPROD_W-1:0]      gprod;
    logic signed [VEC_W-1:0] gainz;
    logic signed [ANG_W-1:0] phi_a;
  } cs2s_side_t;

  // atan(2^-i) in binary angle units, 2^32 per turn
  function automatic logic signed [ANG_W-1:0] atan_bam(input logic [IDX_W-1:0] i);
    logic signed [ANG_W-1:0] r;
    unique case (i)
      5'd0:  r = 34'sh020000000;
      5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B;
      5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43;
      5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E;
      5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53;
      5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98;
      5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6;
      5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA;
      5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE;
      5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30;
      5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C;
      5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3;
      5'd23: r = 34'sh000000051;
      5'd24: r = 34'sh000000029;
      5'd25: r = 34'sh000000014;
      5'd26: r = 34'sh00000000A;
      5'd27: r = 34'sh000000005;
      5'd28: r = 34'sh000000003;
      5'd29: r = 34'sh000000001;
      5'd30: r = 34'sh000000001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/cs2s_prerot.sv
`timescale 1ns / 1ps
module cs2s_prerot
  import cs2s_pkg::*;
(
  input  logic      clk,
  input  cs2s_vec_t v_in,
  output cs2s_vec_t v_out
);

  cs2s_vec_t v_next;

  // rotate into the right half plane by +/- pi/2
  always_comb begin
    v_next = v_in;
    if (v_in.x < 0) begin
      if (v_in.y >= 0) begin
        v_next.x = v_in.y;
        v_next.y = -v_in.x;
        v_next.a = v_in.a + BAM_HALF_PI;
      end else begin
        v_next.x = -v_in.y;
        v_next.y = v_in.x;
        v_next.a = v_in.a - BAM_HALF_PI;
      end
    end
  end

  always_ff @(posedge clk) begin
    v_out <= v_next;
  end

endmodule

FILE: src/cs2s_cell.sv
`timescale 1ns / 1ps
module cs2s_cell
  import cs2s_pkg::*;
(
  input  logic             clk,
  input  logic [IDX_W-1:0] shift,
  input  cs2s_vec_t        v_in,
  output cs2s_vec_t        v_out
);

  cs2s_vec_t               v_next;
  logic signed [VEC_W-1:0] dx;
  logic signed [VEC_W-1:0] dy;
  logic signed [ANG_W-1:0] step;

  always_comb begin
    dx   = v_in.y >>> shift;
    dy   = v_in.x >>> shift;
    step = atan_bam(shift);
    if (v_in.y >= 0) begin
      v_next.x = v_in.x + dx;
      v_next.y = v_in.y - dy;
      v_next.a = v_in.a + step;
    end else begin
      v_next.x = v_in.x - dx;
      v_next.y = v_in.y + dy;
      v_next.a = v_in.a - step;
    end
  end

  always_ff @(posedge clk) begin
    v_out <= v_next;
  end

endmodule

FILE: src/cs2s_q13.sv
`timescale 1ns / 1ps
module cs2s_q13
  import cs2s_pkg::*;
(
  input  logic                    clk,
  input  logic signed [ANG_W-1:0] a,
  output logic signed [AZ_W-1:0]  q
);

  logic [ANG_W-1:0]   mag;
  logic [MAG_W-1:0]   mag_sat;
  logic [QPROD_W-1:0] prod;
  logic               neg;
  logic [QPROD_W-1:0] rounded;
  logic [AZ_W-1:0]    r;

  always_comb begin
    mag = (a < 0) ? ANG_W'(-a) : ANG_W'(a);
    // clamp magnitude to pi
    if (mag > ANG_W'(BAM_PI)) mag_sat = MAG_W'(BAM_PI);
    else                      mag_sat = mag[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod <= QPROD_W'(mag_sat) * QPROD_W'(PI_Q29);
    neg  <= a < 0;
  end

  always_comb begin
    rounded = prod + (QPROD_W'(1) << (Q13_SHIFT - 1));
    r       = AZ_W'(rounded >> Q13_SHIFT);
    q       = neg ? -$signed(r) : $signed(r);
  end

endmodule

FILE: src/cartesian_to_spherical_angles.sv
`timescale 1ns / 1ps
// Timing: done follows the start transfer through the side-data registers sd[0] to sd[LAST] and the done register.
// Throughput: one position per cycle while rst is low; two chains of unrolled CORDIC cells, one per iteration.
// busy is high only while rst is high; results cannot be held off by the receiver.
// Reset: synchronous, clears all valid flags in the chain and the done strobe.
module cartesian_to_spherical_angles
  import cs2s_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic signed [COORD_BITS-1:0] pos_z,
  output logic                      done,
  output logic [POLAR_W-1:0]        polar_angle,
  output logic signed [AZ_W-1:0]    azimuth_angle
);

  localparam int N    = ANGLE_ITERATIONS;
  localparam int LAST = 2 * N + 3;

  cs2s_side_t                   sd      [LAST+1];
  cs2s_side_t                   sd_next [LAST+1];
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic [COORD_BITS:0]          z_mag;
  logic [GPROD_W-1:0]           g_round;
  logic [VEC_W-1:0]             g_mag;
  cs2s_vec_t                    v1 [N+1];
  cs2s_vec_t                    v2 [N+1];
  cs2s_vec_t                    v1_in;
  cs2s_vec_t                    v2_in;
  logic signed [ANG_W-1:0]      theta_a;
  logic signed [AZ_W-1:0]       theta_q;
  logic signed [AZ_W-1:0]       phi_q;
  logic signed [AZ_W-1:0]       phi_sat;
  logic signed [AZ_W-1:0]       theta_sat;
  logic signed [AZ_W-1:0]       phi_next;
  logic signed [AZ_W-1:0]       theta_next;

  assign busy = rst;

  // side data travels beside the vector chain
  always_comb begin
    z_mag = pos_z[COORD_BITS-1] ? (COORD_BITS+1)'(-$signed({pos_z[COORD_BITS-1], pos_z}))
                                : (COORD_BITS+1)'({1'b0, pos_z});
    sd_next[0]        = sd[0];
    sd_next[0].valid  = start && !busy;
    sd_next[0].x_zero = pos_x == '0;
    sd_next[0].y_zero = pos_y == '0;
    sd_next[0].x_pos  = pos_x > 0;
    sd_next[0].y_pos  = pos_y > 0;
    sd_next[0].z_zero = pos_z == '0;
    sd_next[0].z_neg  = pos_z < 0;
    sd_next[0].gprod  = GPROD_W'(z_mag) * GPROD_W'(GAIN_Q30);
    for (int k = 1; k <= LAST; k++) begin
      sd_next[k] = sd[k-1];
    end
    g_round = sd[0].gprod + (GPROD_W'(1) << (GAIN_SHIFT - 1));
    g_mag   = VEC_W'(g_round >> GAIN_SHIFT);
    sd_next[1].gainz   = sd[0].z_neg ? -$signed(g_mag) : $signed(g_mag);
    sd_next[N+2].phi_a = v1[N].a;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) begin
      if (rst) begin
        sd[k].valid <= 1'b0;
      end else begin
        sd[k] <= sd_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    in_x <= pos_x;
    in_y <= pos_y;
  end

  // first chain: (x, y) gives azimuth and K * rho
  always_comb begin
    v1_in.x = $signed({{(VEC_W-COORD_BITS){in_x[COORD_BITS-1]}}, in_x}) <<< GUARD_BITS;
    v1_in.y = $signed({{(VEC_W-COORD_BITS){in_y[COORD_BITS-1]}}, in_y}) <<< GUARD_BITS;
    v1_in.a = '0;
  end

  cs2s_prerot u_pre1 (.clk(clk), .v_in(v1_in), .v_out(v1[0]));

  for (genvar i = 0; i < N; i++) begin : g_chain1
    cs2s_cell u_cell (
      .clk  (clk),
      .shift(IDX_W'(i)),
      .v_in (v1[i]),
      .v_out(v1[i+1])
    );
  end

  // second chain: (K * z, K * rho) gives the polar angle
  always_comb begin
    v2_in.x = sd[N+1].gainz;
    v2_in.y = v1[N].x;
    v2_in.a = '0;
  end

  cs2s_prerot u_pre2 (.clk(clk), .v_in(v2_in), .v_out(v2[0]));

  for (genvar i = 0; i < N; i++) begin : g_chain2
    cs2s_cell u_cell (
      .clk  (clk),
      .shift(IDX_W'(i)),
      .v_in (v2[i]),
      .v_out(v2[i+1])
    );
  end

  assign theta_a = (v2[N].a < 0) ? '0 : v2[N].a;

  cs2s_q13 u_q13_theta (.clk(clk), .a(theta_a),            .q(theta_q));
  cs2s_q13 u_q13_phi   (.clk(clk), .a(sd[LAST-1].phi_a),   .q(phi_q));

  // apply axis rules and saturation
  always_comb begin
    phi_sat   = (phi_q < AZ_LOW) ? AZ_LOW : ((phi_q > Q13_PI) ? Q13_PI : phi_q);
    theta_sat = (theta_q > Q13_PI) ? Q13_PI : theta_q;
    if (sd[LAST].x_zero && sd[LAST].y_zero) begin
      phi_next   = '0;
      theta_next = sd[LAST].z_neg ? Q13_PI : '0;
    end else begin
      if (sd[LAST].y_zero)      phi_next = sd[LAST].x_pos ? '0 : Q13_PI;
      else if (sd[LAST].x_zero) phi_next = sd[LAST].y_pos ? Q13_HALF_PI : -Q13_HALF_PI;
      else                      phi_next = phi_sat;
      theta_next = sd[LAST].z_zero ? Q13_HALF_PI : theta_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= sd[LAST].valid;
    end
    polar_angle   <= theta_next[POLAR_W-1:0];
    azimuth_angle <= phi_next;
  end

endmodule
